@@ design/dsar_pkg.sv @@
package dsar_pkg;

    localparam int MAX_DIMS_DEF = 3;
    localparam int NUM_SLOTS    = 3;
    localparam int DIM_W        = 2;
    localparam int EXT_W        = 16;
    localparam int ELEM_W       = 16;
    localparam int ADDR_W       = 32;
    localparam int OP_W         = 8;

    localparam logic [OP_W-1:0] OP_ADDR        = 8'h03;
    localparam logic [OP_W-1:0] OP_PLUS_UCONST = 8'h23;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_OP   = 3'd1,
        ST_PARTIAL  = 3'd2,
        ST_RANGE    = 3'd3,
        ST_TOO_MANY = 3'd4
    } t_status;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        logic [DIM_W-1:0] step;
        logic             term_en;
    } t_lane_ctrl;

    typedef struct packed {
        logic [ADDR_W-1:0] term;
        logic              oor;
    } t_lane_res;

    typedef struct packed {
        logic [OP_W-1:0]                  op_code;
        logic [ADDR_W-1:0]                op_value;
        logic [ELEM_W-1:0]                elem_size;
        logic [DIM_W-1:0]                 declared_dims;
        logic [DIM_W-1:0]                 used_dims;
        logic [NUM_SLOTS-1:0][EXT_W-1:0]  extent;
        logic [NUM_SLOTS-1:0][EXT_W-1:0]  index;
        logic                             last_part;
    } t_part;

endpackage

@@ design/dsar_lane.sv @@
module dsar_lane #(
    parameter int LANE = 0
) (
    input  logic                                              i_clk,
    input  dsar_pkg::t_lane_ctrl                              i_ctrl,
    input  logic [dsar_pkg::DIM_W-1:0]                        i_decl,
    input  logic [dsar_pkg::DIM_W-1:0]                        i_used,
    input  logic [dsar_pkg::NUM_SLOTS-1:0][dsar_pkg::EXT_W-1:0] i_ext,
    input  logic [dsar_pkg::EXT_W-1:0]                        i_idx,
    output dsar_pkg::t_lane_res                               o_res
);

    localparam int ADDR_W = dsar_pkg::ADDR_W;
    localparam int EXT_W  = dsar_pkg::EXT_W;
    localparam logic [dsar_pkg::DIM_W-1:0] LaneIdx = dsar_pkg::DIM_W'(LANE);

    logic [ADDR_W-1:0]       r_stride;
    logic [ADDR_W-1:0]       r_term;
    logic                    r_oor;
    logic [EXT_W-1:0]        w_opnd;
    logic [ADDR_W+EXT_W-1:0] w_prod;
    logic                    w_active;

    // One shared multiplier: first it builds the stride from the trailing
    // extents, then it scales this lane's index by that stride.
    assign w_opnd   = i_ctrl.term_en ? i_idx : i_ext[i_ctrl.step];
    assign w_prod   = {{EXT_W{1'b0}}, r_stride} * {{ADDR_W{1'b0}}, w_opnd};
    assign w_active = (LaneIdx < i_used);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_stride <= ADDR_W'(1);
        end else if (i_ctrl.mul_en && (i_ctrl.step > LaneIdx) && (i_ctrl.step < i_decl)) begin
            r_stride <= w_prod[ADDR_W-1:0];
        end
        if (i_ctrl.term_en) begin
            r_term <= w_active ? w_prod[ADDR_W-1:0] : '0;
            r_oor  <= w_active && (i_idx >= i_ext[LaneIdx]);
        end
    end

    assign o_res.term = r_term;
    assign o_res.oor  = r_oor;

endmodule

@@ design/dsar_merge.sv @@
module dsar_merge #(
    parameter int MAX_DIMS = dsar_pkg::MAX_DIMS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_fire,
    input  dsar_pkg::t_part                       i_part,
    input  logic [dsar_pkg::DIM_W-1:0]            i_decl,
    input  dsar_pkg::t_lane_res [MAX_DIMS-1:0]    i_lanes,
    input  logic                                  i_out_ready,
    output logic                                  o_can_take,
    output logic                                  o_out_valid,
    output logic [dsar_pkg::ADDR_W-1:0]           o_address,
    output dsar_pkg::t_status                     o_status
);

    localparam int ADDR_W = dsar_pkg::ADDR_W;
    localparam int ELEM_W = dsar_pkg::ELEM_W;
    localparam logic [dsar_pkg::DIM_W-1:0] MaxDims = dsar_pkg::DIM_W'(MAX_DIMS);

    logic                     r_at_first, n_at_first;
    logic [ADDR_W-1:0]        r_acc, n_acc;
    dsar_pkg::t_status        r_err, n_err;
    logic                     r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]        r_address, n_address;
    dsar_pkg::t_status        r_status, n_status;

    logic [ADDR_W-1:0]        w_sum;
    logic                     w_any_oor;
    logic [ADDR_W+ELEM_W-1:0] w_scaled;
    logic [ADDR_W-1:0]        w_base;
    logic                     w_op_ok;
    dsar_pkg::t_status        w_arr_st;
    dsar_pkg::t_status        w_part_st;

    always_comb begin
        w_sum     = '0;
        w_any_oor = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_sum     = w_sum + i_lanes[d].term;
            w_any_oor = w_any_oor | i_lanes[d].oor;
        end
    end

    assign w_scaled = {{ELEM_W{1'b0}}, w_sum} * {{ADDR_W{1'b0}}, i_part.elem_size};

    always_comb begin
        w_base  = '0;
        w_op_ok = 1'b0;
        if (r_at_first && (i_part.op_code == dsar_pkg::OP_ADDR)) begin
            w_base  = i_part.op_value;
            w_op_ok = 1'b1;
        end else if (!r_at_first && (i_part.op_code == dsar_pkg::OP_PLUS_UCONST)) begin
            w_base  = r_acc + i_part.op_value;
            w_op_ok = 1'b1;
        end
    end

    always_comb begin
        priority if (i_part.used_dims == '0) begin
            w_arr_st = dsar_pkg::ST_OK;
        end else if ((i_part.used_dims > MaxDims) || (i_part.used_dims > i_decl)) begin
            w_arr_st = dsar_pkg::ST_TOO_MANY;
        end else if (!i_part.last_part && (i_part.used_dims != i_decl)) begin
            w_arr_st = dsar_pkg::ST_PARTIAL;
        end else if (w_any_oor) begin
            w_arr_st = dsar_pkg::ST_RANGE;
        end else begin
            w_arr_st = dsar_pkg::ST_OK;
        end
    end

    assign w_part_st = w_op_ok ? w_arr_st : dsar_pkg::ST_BAD_OP;

    always_comb begin
        n_at_first  = r_at_first;
        n_acc       = r_acc;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_address   = r_address;
        n_status    = r_status;
        if (i_fire) begin
            n_at_first = 1'b0;
            // Once an error is recorded, the rest of the path is ignored.
            if (r_err == dsar_pkg::ST_OK) begin
                if (w_part_st == dsar_pkg::ST_OK) begin
                    n_acc = w_base + w_scaled[ADDR_W-1:0];
                end else begin
                    n_err = w_part_st;
                end
            end
            if (i_part.last_part) begin
                n_out_valid = 1'b1;
                n_address   = (n_err == dsar_pkg::ST_OK) ? n_acc : '0;
                n_status    = n_err;
                n_at_first  = 1'b1;
                n_acc       = '0;
                n_err       = dsar_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_first  <= 1'b1;
            r_acc       <= '0;
            r_err       <= dsar_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_at_first  <= n_at_first;
            r_acc       <= n_acc;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_address <= n_address;
        r_status  <= n_status;
    end

    assign o_can_take  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_address   = r_address;
    assign o_status    = r_status;

endmodule

@@ design/debug_symbol_address_resolver_core.sv @@
// Channel   | Direction | Payload
// ----------+-----------+-------------------------------------------------
// s_axis    | in        | one path part; tuser op_code, tlast last_part
// m_axis    | out       | resolved address in tdata, status in tuser
//
// A part runs through the accept step, MAX_DIMS - 1 stride
// steps through each lane's shared multiplier, one index scaling step, and
// the merge step that scales by the element size and updates the path state.
// Reset is synchronous and active low; it returns the block to expecting the
// first part of a path. A last part waits in the merge step while the output
// register holds an untaken result; other parts never wait on the output.
module debug_symbol_address_resolver_core #(
    parameter int MAX_DIMS = dsar_pkg::MAX_DIMS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: op_value[31:0], elem_size[47:32], declared_dims[49:48],
    // used_dims[51:50], extent0[67:52], extent1[83:68], extent2[99:84],
    // index0[115:100], index1[131:116], index2[147:132], zero fill[151:148].
    input  logic [151:0] s_axis_tdata,
    // Fields from bit 0: op_code[7:0].
    input  logic [7:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: address[31:0].
    output logic [31:0]  m_axis_tdata,
    // Fields from bit 0: status[2:0].
    output logic [2:0]   m_axis_tuser
);

    localparam int DIM_W = dsar_pkg::DIM_W;
    localparam logic [DIM_W-1:0] MaxDims  = DIM_W'(MAX_DIMS);
    localparam logic [DIM_W-1:0] LastStep = DIM_W'(MAX_DIMS - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_STRIDE = 4'b0010,
        S_TERM   = 4'b0100,
        S_MERGE  = 4'b1000
    } t_state;

    t_state                              r_state, n_state;
    logic [DIM_W-1:0]                    r_step, n_step;
    dsar_pkg::t_part                     r_part;
    logic [DIM_W-1:0]                    w_decl;
    logic                                w_accept;
    logic                                w_can_take;
    logic                                w_fire;
    dsar_pkg::t_lane_ctrl                w_ctrl;
    dsar_pkg::t_lane_res [MAX_DIMS-1:0]  w_lanes;
    dsar_pkg::t_status                   w_status;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_fire        = (r_state == S_MERGE) && (!r_part.last_part || w_can_take);
    assign w_decl        = (r_part.declared_dims > MaxDims) ? MaxDims : r_part.declared_dims;

    assign w_ctrl.load    = w_accept;
    assign w_ctrl.mul_en  = (r_state == S_STRIDE);
    assign w_ctrl.step    = r_step;
    assign w_ctrl.term_en = (r_state == S_TERM);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (MAX_DIMS > 1) ? S_STRIDE : S_TERM;
                    n_step  = DIM_W'(1);
                end
            end
            S_STRIDE: begin
                if (r_step == LastStep) begin
                    n_state = S_TERM;
                end else begin
                    n_step = r_step + DIM_W'(1);
                end
            end
            S_TERM: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_part.op_code       <= s_axis_tuser;
            r_part.op_value      <= s_axis_tdata[31:0];
            r_part.elem_size     <= s_axis_tdata[47:32];
            r_part.declared_dims <= s_axis_tdata[49:48];
            r_part.used_dims     <= s_axis_tdata[51:50];
            r_part.extent[0]     <= s_axis_tdata[67:52];
            r_part.extent[1]     <= s_axis_tdata[83:68];
            r_part.extent[2]     <= s_axis_tdata[99:84];
            r_part.index[0]      <= s_axis_tdata[115:100];
            r_part.index[1]      <= s_axis_tdata[131:116];
            r_part.index[2]      <= s_axis_tdata[147:132];
            r_part.last_part     <= s_axis_tlast;
        end
    end

    for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lane
        dsar_lane #(
            .LANE(g)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_decl (w_decl),
            .i_used (r_part.used_dims),
            .i_ext  (r_part.extent),
            .i_idx  (r_part.index[g]),
            .o_res  (w_lanes[g])
        );
    end

    dsar_merge #(
        .MAX_DIMS(MAX_DIMS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_part      (r_part),
        .i_decl      (w_decl),
        .i_lanes     (w_lanes),
        .i_out_ready (m_axis_tready),
        .o_can_take  (w_can_take),
        .o_out_valid (m_axis_tvalid),
        .o_address   (m_axis_tdata),
        .o_status    (w_status)
    );

    assign m_axis_tuser = w_status;

endmodule

@@ design/dsar_checker.sv @@
module dsar_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [151:0] s_axis_tdata,
    input logic [7:0]   s_axis_tuser,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    // A pending result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed before its transaction completed");

    // Parts are worked one at a time, so an accepted part closes the input.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input reopened right after a transaction");

    // A failed path reports a zero address.
    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != dsar_pkg::ST_OK) |-> (m_axis_tdata == 32'd0))
        else $error("nonzero address reported with an error status");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= dsar_pkg::ST_TOO_MANY))
        else $error("undefined status code on the output");

    // A new result only appears at the end of a part's work.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared while the block was idle");

endmodule

bind debug_symbol_address_resolver_core dsar_checker u_dsar_checker (.*);
